/* design/wsrm_pkg.sv */
`timescale 1ns / 1ps

package wsrm_pkg;

  // Item kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_SCAN  = 1'b1;

  // Result actions.
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_ON   = 2'd1;
  localparam logic [1:0] ACT_OFF  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_CHANNELS = 1'b0;
  localparam logic CFG_AUTO     = 1'b1;

  // A scan reports on at most this many channels.
  localparam int MAX_SCAN = 4;

  typedef struct packed {
    logic       kind;
    logic [1:0] channel_sel;
    logic [5:0] entry_index;
    logic       entry_enable;
    logic [3:0] entry_week_pattern;
    logic [4:0] entry_hour;
    logic [5:0] entry_minute;
    logic [2:0] now_weekday;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
  } in_word_t;

  typedef struct packed {
    logic [1:0] relay_channel;
    logic [1:0] action;
    logic       last;
  } out_word_t;

  // One stored schedule entry.
  typedef struct packed {
    logic       enable;
    logic [3:0] pattern;
    logic [4:0] hour;
    logic [5:0] minute;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_we;
    logic wr_we;
    logic load_now;
    logic rd_en;
    logic acc_clr;
    logic emit;
    logic last;
  } cmd_t;

  // Weekday sets, bit 0 is Monday. Pattern 15 never matches.
  function automatic logic [6:0] day_mask(input logic [3:0] pattern);
    logic [6:0] m;
    case (pattern)
      4'd0:    m = 7'h7F;
      4'd1:    m = 7'h01;
      4'd2:    m = 7'h02;
      4'd3:    m = 7'h04;
      4'd4:    m = 7'h08;
      4'd5:    m = 7'h10;
      4'd6:    m = 7'h20;
      4'd7:    m = 7'h40;
      4'd8:    m = 7'h1F;
      4'd9:    m = 7'h60;
      4'd10:   m = 7'h3F;
      4'd11:   m = 7'h15;
      4'd12:   m = 7'h2A;
      4'd13:   m = 7'h07;
      4'd14:   m = 7'h38;
      default: m = 7'h00;
    endcase
    return m;
  endfunction

endpackage

/* design/wsrm_ctrl.sv */
`timescale 1ns / 1ps

module wsrm_ctrl import wsrm_pkg::*; #(
  parameter int CHANNELS            = 4,
  parameter int ENTRIES_PER_CHANNEL = 56,
  parameter int EW                  = $clog2(ENTRIES_PER_CHANNEL),
  parameter int AW                  = $clog2(CHANNELS * ENTRIES_PER_CHANNEL)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_kind,
  input  logic [1:0]    in_channel_sel,
  input  logic [5:0]    in_entry_index,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [3:0]    cfg_data,
  input  logic          out_free,
  output cmd_t          cmd,
  output logic [1:0]    ch_idx,
  output logic [EW-1:0] ent_idx,
  output logic [AW-1:0] clr_addr
);

  localparam int DEPTH = CHANNELS * ENTRIES_PER_CHANNEL;
  localparam int NSCAN = (CHANNELS < MAX_SCAN) ? CHANNELS : MAX_SCAN;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CH_START,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t                state_r, state_nxt;
  logic [1:0]            ch_r, ch_nxt;
  logic [EW-1:0]         ent_r, ent_nxt;
  logic [AW-1:0]         clr_r, clr_nxt;
  logic [MAX_SCAN-1:0]   active_r, active_nxt;
  logic [2:0]            chans_r, chans_nxt;
  logic [MAX_SCAN-1:0]   auto_r, auto_nxt;
  logic [MAX_SCAN-1:0]   remain;
  logic                  accept;
  logic                  wr_ok;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign wr_ok    = (32'(in_channel_sel) < CHANNELS) &&
                    (32'(in_entry_index) < ENTRIES_PER_CHANNEL);
  assign remain   = active_r >> ch_r;

  assign ch_idx   = ch_r;
  assign ent_idx  = ent_r;
  assign clr_addr = clr_r;

  always_comb begin
    state_nxt  = state_r;
    ch_nxt     = ch_r;
    ent_nxt    = ent_r;
    clr_nxt    = clr_r;
    active_nxt = active_r;
    chans_nxt  = chans_r;
    auto_nxt   = auto_r;
    cmd        = '0;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHANNELS: chans_nxt = cfg_data[2:0];
        CFG_AUTO:     auto_nxt  = cfg_data;
      endcase
    end

    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_WRITE) begin
            cmd.wr_we = wr_ok;
          end else begin
            cmd.load_now = 1'b1;
            for (int i = 0; i < MAX_SCAN; i++) begin
              active_nxt[i] = auto_r[i] && (i < NSCAN) && (i < 32'(chans_r));
            end
            ch_nxt    = '0;
            state_nxt = S_CH_START;
          end
        end
      end
      S_CH_START: begin
        if (remain == '0) begin
          state_nxt = S_IDLE;
        end else if (remain[0]) begin
          cmd.acc_clr = 1'b1;
          ent_nxt     = '0;
          state_nxt   = S_SCAN;
        end else begin
          ch_nxt = ch_r + 1'b1;
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        ent_nxt   = ent_r + 1'b1;
        if (ent_r == EW'(ENTRIES_PER_CHANNEL - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          cmd.last = ((remain >> 1) == '0);
          if (cmd.last) begin
            state_nxt = S_IDLE;
          end else begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = S_CH_START;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      ch_r     <= '0;
      ent_r    <= '0;
      clr_r    <= '0;
      active_r <= '0;
      chans_r  <= 3'd1;
      auto_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      ch_r     <= ch_nxt;
      ent_r    <= ent_nxt;
      clr_r    <= clr_nxt;
      active_r <= active_nxt;
      chans_r  <= chans_nxt;
      auto_r   <= auto_nxt;
    end
  end

endmodule

/* design/wsrm_dp.sv */
`timescale 1ns / 1ps

module wsrm_dp import wsrm_pkg::*; #(
  parameter int CHANNELS            = 4,
  parameter int ENTRIES_PER_CHANNEL = 56,
  parameter int EW                  = $clog2(ENTRIES_PER_CHANNEL),
  parameter int AW                  = $clog2(CHANNELS * ENTRIES_PER_CHANNEL)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  in_word_t      in_data,
  input  cmd_t          cmd,
  input  logic [1:0]    ch_idx,
  input  logic [EW-1:0] ent_idx,
  input  logic [AW-1:0] clr_addr,
  output logic          out_free,
  output logic          out_valid,
  input  logic          out_stall,
  output out_word_t     out_data
);

  localparam int DEPTH = CHANNELS * ENTRIES_PER_CHANNEL;

  entry_t        mem [DEPTH];
  entry_t        rd_word_r;
  logic          rd_valid_r;
  logic          rd_odd_r;
  logic [6:0]    today_r;
  logic [4:0]    hour_r;
  logic [5:0]    minute_r;
  logic          on_hit_r, off_hit_r;
  logic          out_valid_r;
  out_word_t     out_word_r;

  logic [AW-1:0] wr_addr, rd_addr;
  entry_t        wr_word;
  logic          hit;
  logic [1:0]    action;

  assign rd_addr = AW'(32'(ch_idx) * ENTRIES_PER_CHANNEL + 32'(ent_idx));

  always_comb begin
    if (cmd.clr_we) begin
      wr_addr = clr_addr;
      wr_word = '0;
    end else begin
      wr_addr = AW'(32'(in_data.channel_sel) * ENTRIES_PER_CHANNEL +
                    32'(in_data.entry_index));
      wr_word = '{enable:  in_data.entry_enable,
                  pattern: in_data.entry_week_pattern,
                  hour:    in_data.entry_hour,
                  minute:  in_data.entry_minute};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_we || cmd.wr_we) begin
      mem[wr_addr] <= wr_word;
    end
    if (cmd.rd_en) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  // An entry hits when it is enabled, today is in its day set and the time agrees.
  assign hit = rd_valid_r && rd_word_r.enable &&
               ((day_mask(rd_word_r.pattern) & today_r) != '0) &&
               (rd_word_r.hour == hour_r) && (rd_word_r.minute == minute_r);

  always_comb begin
    if (on_hit_r && !off_hit_r) begin
      action = ACT_ON;
    end else if (off_hit_r && !on_hit_r) begin
      action = ACT_OFF;
    end else begin
      action = ACT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    rd_odd_r <= ent_idx[0];
    if (cmd.load_now) begin
      today_r  <= (in_data.now_weekday < 3'd7) ? (7'd1 << in_data.now_weekday) : 7'd0;
      hour_r   <= in_data.now_hour;
      minute_r <= in_data.now_minute;
    end
    if (cmd.acc_clr) begin
      on_hit_r  <= 1'b0;
      off_hit_r <= 1'b0;
    end else if (hit) begin
      if (rd_odd_r) begin
        off_hit_r <= 1'b1;
      end else begin
        on_hit_r <= 1'b1;
      end
    end
    if (cmd.emit) begin
      out_word_r <= '{relay_channel: ch_idx, action: action, last: cmd.last};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= cmd.rd_en;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

/* design/weekly_schedule_relay_matcher_top.sv */
`timescale 1ns / 1ps

// Channel | Direction | Handshake        | Word
// in_     | input     | valid / stall    | in_word_t: entry write or scan at current time
// out_    | output    | valid / stall    | out_word_t: relay channel, action, last flag
// cfg_    | input     | write enable     | index 0 channels in use, index 1 auto mode mask
//
// A write word does not block the input, which stays open for the next word.
// A scan reads every entry of each automatic channel it covers in turn through the
// single memory read port, steps over the other channels, and holds in_stall high
// until it is done.
// After reset a clearing pass zeroes all CHANNELS * ENTRIES_PER_CHANNEL entries of the
// schedule store, and in_stall stays high until it is done.
// A stall on the output holds the scan at its next result; the final result of a scan
// may wait in the output register while the next input word is taken.

module weekly_schedule_relay_matcher_top import wsrm_pkg::*; #(
  parameter int CHANNELS            = 4,
  parameter int ENTRIES_PER_CHANNEL = 56
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [3:0] cfg_data
);

  // Width of the entry counter within one channel and of the store address.
  localparam int EW = $clog2(ENTRIES_PER_CHANNEL);
  localparam int AW = $clog2(CHANNELS * ENTRIES_PER_CHANNEL);

  cmd_t          cmd;
  logic [1:0]    ch_idx;
  logic [EW-1:0] ent_idx;
  logic [AW-1:0] clr_addr;
  logic          out_free;

  // The controller sequences clearing, writes and the channel-by-channel scan.
  wsrm_ctrl #(
    .CHANNELS            (CHANNELS),
    .ENTRIES_PER_CHANNEL (ENTRIES_PER_CHANNEL),
    .EW                  (EW),
    .AW                  (AW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_data.kind),
    .in_channel_sel (in_data.channel_sel),
    .in_entry_index (in_data.entry_index),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_free       (out_free),
    .cmd            (cmd),
    .ch_idx         (ch_idx),
    .ent_idx        (ent_idx),
    .clr_addr       (clr_addr)
  );

  // The datapath owns the schedule store, the match logic and the output register.
  wsrm_dp #(
    .CHANNELS            (CHANNELS),
    .ENTRIES_PER_CHANNEL (ENTRIES_PER_CHANNEL),
    .EW                  (EW),
    .AW                  (AW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .ch_idx    (ch_idx),
    .ent_idx   (ent_idx),
    .clr_addr  (clr_addr),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* design/wsrm_checker.sv */
`timescale 1ns / 1ps

module wsrm_checker import wsrm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  // Only defined action codes leave the block.
  a_action_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.action == ACT_NONE || out_data.action == ACT_ON ||
                   out_data.action == ACT_OFF))
    else $error("undefined action code");

  // A write word never blocks the input.
  a_write_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.kind == KIND_WRITE |=> !in_stall)
    else $error("input blocked after a write word");

  // A scan word occupies the block for at least the next cycle.
  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.kind == KIND_SCAN |=> in_stall)
    else $error("input open right after a scan word");

endmodule

bind weekly_schedule_relay_matcher_top wsrm_checker u_wsrm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* bench/tb_weekly_schedule_relay_matcher_top.sv */
`timescale 1ns / 1ps

// Self-checking bench for the weekly relay schedule matcher.
// A directed table runs first, then four random phases, each with its own register
// setting. Every accepted input word goes through the bench's own schedule predictor.
// Every accepted output word is checked field by field against the oldest pending
// relay decision.
module tb_weekly_schedule_relay_matcher_top;
  import wsrm_pkg::*;

  localparam int CHAN_N         = 4;
  localparam int SLOTS          = 56;
  // Worst scan: every channel automatic, each one a full walk of its slots.
  localparam int SCAN_CYCLES    = CHAN_N * (SLOTS + 3);
  localparam int SETTLE         = SCAN_CYCLES + 8;
  localparam int HOLD_LEN       = 400;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int PHASE_WORDS    = 35;
  localparam int HOT_N          = 6;

  // Weekday bits, Monday in bit 0.
  localparam logic [6:0] MON = 7'h01, TUE = 7'h02, WED = 7'h04, THU = 7'h08;
  localparam logic [6:0] FRI = 7'h10, SAT = 7'h20, SUN = 7'h40;

  // Days covered by each week pattern, pattern 15 first. Pattern 15 covers no day.
  localparam logic [15:0][6:0] WEEK_SETS = {
    7'h00, THU | FRI | SAT, MON | TUE | WED, TUE | THU | SAT, MON | WED | FRI,
    MON | TUE | WED | THU | FRI | SAT, SAT | SUN, MON | TUE | WED | THU | FRI,
    SUN, SAT, FRI, THU, WED, TUE, MON, 7'h7F
  };

  // Results pinned by hand in the directed table. When fixed is clear the predictor
  // decides what the word must produce.
  typedef struct packed {
    logic            fixed;
    logic [2:0]      count;
    out_word_t [3:0] res;
  } hand_exp_t;

  // One row of the directed table: a register write or an input word.
  typedef struct packed {
    logic       is_reg;
    logic       reg_idx;
    logic [3:0] reg_val;
    in_word_t   word;
    hand_exp_t  hand;
  } stim_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  logic      cfg_we    = 1'b0;
  logic      cfg_index = 1'b0;
  logic [3:0] cfg_data = '0;

  // Predictor state: the schedule store and the two registers.
  entry_t     sched [CHAN_N * SLOTS];
  logic [2:0] chan_count;
  logic [3:0] auto_mask;

  out_word_t  pending_actions [$];
  hand_exp_t  hand_exp_q [$];
  stim_row_t  script [$];
  int         mismatches = 0;
  int         quiet_cycles = 0;

  // Idling controls. The percentages are changed by phase; zero means no idling.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_ticket = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int rx_burst    = 0;

  // Times that the random part keeps reusing, so that writes and scans meet.
  logic [2:0] hot_wd [HOT_N];
  logic [4:0] hot_hr [HOT_N];
  logic [5:0] hot_mn [HOT_N];

  weekly_schedule_relay_matcher_top #(
    .CHANNELS            (CHAN_N),
    .ENTRIES_PER_CHANNEL (SLOTS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Works out the relay decisions one accepted word causes. A write only updates the
  // store; slots past the end of a channel are dropped. A scan walks every automatic
  // channel among the first ones in use, at most four of them.
  task automatic predict_relay_actions(input in_word_t w, input hand_exp_t hand);
    out_word_t  found [$];
    out_word_t  r;
    entry_t     ent;
    logic [6:0] today;
    logic       on_hit;
    logic       off_hit;
    int         span;
    if (w.kind == KIND_WRITE) begin
      if (int'(w.entry_index) < SLOTS)
        sched[int'(w.channel_sel) * SLOTS + int'(w.entry_index)] =
          {w.entry_enable, w.entry_week_pattern, w.entry_hour, w.entry_minute};
    end else begin
      // Weekday 7 is not in any day set, so nothing can match on it.
      today = (w.now_weekday == 3'd7) ? 7'd0 : (7'd1 << w.now_weekday);
      span = int'(chan_count);
      if (span > CHAN_N) span = CHAN_N;
      if (span > MAX_SCAN) span = MAX_SCAN;
      for (int c = 0; c < span; c++) begin
        if (auto_mask[c]) begin
          on_hit  = 1'b0;
          off_hit = 1'b0;
          for (int e = 0; e < SLOTS; e++) begin
            ent = sched[c * SLOTS + e];
            // Hour and minute compare as raw bits, out of range values included.
            if (ent.enable && (WEEK_SETS[ent.pattern] & today) != 7'd0 &&
                ent.hour == w.now_hour && ent.minute == w.now_minute) begin
              if (e % 2 == 0) on_hit = 1'b1;
              else off_hit = 1'b1;
            end
          end
          r.relay_channel = 2'(c);
          r.action = (on_hit && !off_hit) ? ACT_ON :
                     (off_hit && !on_hit) ? ACT_OFF : ACT_NONE;
          r.last = 1'b0;
          found.push_back(r);
        end
      end
      if (found.size() > 0) found[found.size() - 1].last = 1'b1;
    end
    // Pinned rows replace the predicted list; the store update above still happens.
    if (hand.fixed) begin
      for (int i = 0; i < int'(hand.count); i++) pending_actions.push_back(hand.res[i]);
    end else begin
      foreach (found[i]) pending_actions.push_back(found[i]);
    end
  endtask

  task automatic check_action(input out_word_t got);
    out_word_t want;
    if (pending_actions.size() == 0) begin
      $display("%0t: unexpected relay word ch %0d action %0d last %0d", $time,
               got.relay_channel, got.action, got.last);
      mismatches++;
    end else begin
      want = pending_actions.pop_front();
      if (got.relay_channel !== want.relay_channel) begin
        $display("%0t: relay_channel expected %0d got %0d", $time,
                 want.relay_channel, got.relay_channel);
        mismatches++;
      end
      if (got.action !== want.action) begin
        $display("%0t: action on ch %0d expected %0d got %0d", $time,
                 want.relay_channel, want.action, got.action);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last on ch %0d expected %0d got %0d", $time,
                 want.relay_channel, want.last, got.last);
        mismatches++;
      end
    end
  endtask

  // All handshakes are sampled here, at the rising edge, from values that were set up
  // at the falling edge before it.
  always @(posedge clk) begin
    hand_exp_t hand;
    if (!rst_n) begin
      foreach (sched[i]) sched[i] = '0;
      chan_count = 3'd1;
      auto_mask  = 4'd0;
    end else begin
      if (out_valid && !out_stall) check_action(out_data);
      if (in_valid && !in_stall) begin
        hand = (hand_exp_q.size() != 0) ? hand_exp_q.pop_front() : '0;
        predict_relay_actions(in_data, hand);
      end
      if (cfg_we) begin
        if (cfg_index == CFG_CHANNELS) chan_count = cfg_data[2:0];
        else auto_mask = cfg_data;
      end
    end
  end

  // A run is stuck if nothing crosses either channel for this long. The longest honest
  // gap is the long receiver hold-off or a settle pause, both far shorter.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("weekly_schedule_relay_matcher_top: mismatch");
        $finish;
      end
    end
  end

  // Receiver side. A raised hold ticket starts one long hold-off, counted here; apart
  // from that the stall comes in random bursts.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_seen != hold_ticket) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_LEN - 1;
      out_stall <= 1'b1;
    end else if (rx_burst != 0) begin
      rx_burst = rx_burst - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(99) < rx_idle_pct) begin
      rx_burst = $urandom_range(19, 1) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offers one word, maybe after an idle burst, and returns on the falling edge after
  // it was taken. Valid stays high so the next word can follow without a gap.
  task automatic offer_word(input in_word_t w, input hand_exp_t hand);
    int gap;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      gap = $urandom_range(19, 1);
      repeat (gap) @(negedge clk);
    end
    hand_exp_q.push_back(hand);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Drops valid and waits until every pending decision is in, then lets a full scan's
  // time pass, since a scan with no automatic channel gives no word to wait for.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_actions.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [3:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic stim_row_t reg_row(input logic idx, input logic [3:0] val);
    stim_row_t r;
    r = '0;
    r.is_reg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic stim_row_t entry_row(input logic [1:0] ch, input logic [5:0] slot,
                                          input logic en, input logic [3:0] pat,
                                          input logic [4:0] hr, input logic [5:0] mn);
    stim_row_t r;
    r = '0;
    r.word.kind               = KIND_WRITE;
    r.word.channel_sel        = ch;
    r.word.entry_index        = slot;
    r.word.entry_enable       = en;
    r.word.entry_week_pattern = pat;
    r.word.entry_hour         = hr;
    r.word.entry_minute       = mn;
    return r;
  endfunction

  function automatic stim_row_t scan_row(input logic [2:0] wd, input logic [4:0] hr,
                                         input logic [5:0] mn);
    stim_row_t r;
    r = '0;
    r.word.kind        = KIND_SCAN;
    r.word.now_weekday = wd;
    r.word.now_hour    = hr;
    r.word.now_minute  = mn;
    return r;
  endfunction

  function automatic out_word_t act_word(input logic [1:0] ch, input logic [1:0] act,
                                         input logic last);
    out_word_t o;
    o.relay_channel = ch;
    o.action        = act;
    o.last          = last;
    return o;
  endfunction

  function automatic stim_row_t pinned_scan(input logic [2:0] wd, input logic [4:0] hr,
                                            input logic [5:0] mn, input logic [2:0] n,
                                            input out_word_t r0, input out_word_t r1,
                                            input out_word_t r2, input out_word_t r3);
    stim_row_t r;
    r = scan_row(wd, hr, mn);
    r.hand.fixed = 1'b1;
    r.hand.count = n;
    r.hand.res   = {r3, r2, r1, r0};
    return r;
  endfunction

  // Random word. Every field starts as noise so that all bits move; most words then get
  // a hot time so that writes and later scans line up.
  function automatic in_word_t random_word();
    in_word_t    w;
    logic [63:0] noise;
    int          h;
    noise = {$urandom, $urandom};
    w = noise[$bits(in_word_t)-1:0];
    h = $urandom_range(HOT_N - 1);
    if ($urandom_range(99) < 40) begin
      w.kind = KIND_SCAN;
      if ($urandom_range(99) < 85) begin
        w.now_weekday = ($urandom_range(99) < 4) ? 3'd7 : hot_wd[h];
        w.now_hour    = hot_hr[h];
        w.now_minute  = hot_mn[h];
      end
    end else begin
      w.kind = KIND_WRITE;
      w.entry_index  = ($urandom_range(99) < 90) ? 6'($urandom_range(SLOTS - 1)) :
                                                   6'($urandom_range(63, SLOTS));
      w.entry_enable = ($urandom_range(99) < 85);
      if ($urandom_range(99) < 80) begin
        w.entry_hour   = hot_hr[h];
        w.entry_minute = hot_mn[h];
      end
    end
    return w;
  endfunction

  initial begin
    stim_row_t row;
    logic [3:0] chan_val;
    logic [3:0] auto_val;

    // After reset one channel is in use and none is automatic.
    script.push_back(pinned_scan(3'd0, 5'd0, 6'd0, 3'd0, '0, '0, '0, '0));
    script.push_back(reg_row(CFG_AUTO, 4'hF));
    // Channel 0 alone, store freshly cleared.
    script.push_back(pinned_scan(3'd0, 5'd0, 6'd0, 3'd1,
                                 act_word(2'd0, ACT_NONE, 1'b1), '0, '0, '0));
    script.push_back(reg_row(CFG_CHANNELS, 4'd4));
    script.push_back(entry_row(2'd0, 6'd0, 1'b1, 4'd0, 5'd0, 6'd0));
    // Slots past the end of the channel are dropped. Kept, they would land in channel 1
    // and show up there in the midnight scan or in the scans at the raw maximum time.
    script.push_back(entry_row(2'd0, 6'd63, 1'b1, 4'd0, 5'd31, 6'd63));
    script.push_back(entry_row(2'd0, 6'd56, 1'b1, 4'd0, 5'd0, 6'd0));
    script.push_back(entry_row(2'd1, 6'd1, 1'b1, 4'd0, 5'd23, 6'd59));
    // A disabled on-slot must not cancel the off-slot above.
    script.push_back(entry_row(2'd1, 6'd2, 1'b0, 4'd0, 5'd23, 6'd59));
    // Last slot, Thursday to Saturday, hour and minute at their raw maximum.
    script.push_back(entry_row(2'd2, 6'd55, 1'b1, 4'd14, 5'd31, 6'd63));
    // Empty day set, then a Sunday on-slot against a weekend off-slot.
    script.push_back(entry_row(2'd3, 6'd54, 1'b1, 4'd15, 5'd12, 6'd30));
    script.push_back(entry_row(2'd3, 6'd0, 1'b1, 4'd7, 5'd12, 6'd30));
    script.push_back(entry_row(2'd3, 6'd1, 1'b1, 4'd9, 5'd12, 6'd30));
    script.push_back(pinned_scan(3'd0, 5'd0, 6'd0, 3'd4,
                                 act_word(2'd0, ACT_ON, 1'b0),
                                 act_word(2'd1, ACT_NONE, 1'b0),
                                 act_word(2'd2, ACT_NONE, 1'b0),
                                 act_word(2'd3, ACT_NONE, 1'b1)));
    script.push_back(scan_row(3'd6, 5'd23, 6'd59));
    script.push_back(scan_row(3'd5, 5'd31, 6'd63));
    // Weekday 7 matches nothing, whatever the time.
    script.push_back(pinned_scan(3'd7, 5'd31, 6'd63, 3'd4,
                                 act_word(2'd0, ACT_NONE, 1'b0),
                                 act_word(2'd1, ACT_NONE, 1'b0),
                                 act_word(2'd2, ACT_NONE, 1'b0),
                                 act_word(2'd3, ACT_NONE, 1'b1)));
    script.push_back(scan_row(3'd6, 5'd12, 6'd30));
    script.push_back(scan_row(3'd5, 5'd12, 6'd30));
    // No channel in use: the scan gives no word at all.
    script.push_back(reg_row(CFG_CHANNELS, 4'd0));
    script.push_back(pinned_scan(3'd0, 5'd0, 6'd0, 3'd0, '0, '0, '0, '0));
    // Count above the channel number is clipped to four channels.
    script.push_back(reg_row(CFG_CHANNELS, 4'd7));
    script.push_back(reg_row(CFG_AUTO, 4'b1010));
    script.push_back(scan_row(3'd3, 5'd31, 6'd63));
    script.push_back(reg_row(CFG_CHANNELS, 4'd2));
    script.push_back(reg_row(CFG_AUTO, 4'b0101));
    script.push_back(scan_row(3'd0, 5'd0, 6'd0));

    // Synchronous reset, released on a falling edge.
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 20;
    rx_idle_pct = 8;
    foreach (script[i]) begin
      row = script[i];
      if (row.is_reg) begin
        wait_idle();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        offer_word(row.word, row.hand);
      end
    end

    foreach (hot_wd[i]) begin
      hot_wd[i] = 3'($urandom_range(6));
      hot_hr[i] = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 24)) :
                                             5'($urandom_range(23));
      hot_mn[i] = ($urandom_range(9) == 0) ? 6'($urandom_range(63, 60)) :
                                             6'($urandom_range(59));
    end

    // Phase 0: all channels automatic, both sides idling.
    // Phase 1: the receiver holds off for a long stretch while words keep coming.
    // Phase 2: the sender pauses midway until every decision is in.
    // Phase 3: no idling at all on either side.
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      chan_val = (ph == 0 || ph == 3) ? 4'd4 : 4'($urandom_range(7, 1));
      chan_val[3] = 1'($urandom_range(1));
      auto_val = (ph == 0) ? 4'hF : 4'($urandom_range(15, 1));
      // Every scan must report during the long hold-off, so channel 0 stays automatic.
      if (ph == 1) auto_val[0] = 1'b1;
      write_reg(CFG_CHANNELS, chan_val);
      write_reg(CFG_AUTO, auto_val);
      tx_idle_pct = (ph < 2) ? 30 : 0;
      rx_idle_pct = (ph == 0) ? 8 : (ph == 2) ? 10 : 0;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (ph == 1 && k == 10) hold_ticket <= hold_ticket + 1;
        if (ph == 2 && k == 20) wait_idle();
        offer_word(random_word(), '0);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("weekly_schedule_relay_matcher_top: match");
    end else begin
      $display("weekly_schedule_relay_matcher_top: mismatch");
    end
    $finish;
  end

endmodule
